FILE: rtl/core/dmfe_pkg.sv
// ----------------------------------------------------------------------------
// dmfe_pkg: shared definitions for the double marker frame extractor
// Marker byte codes and the command/status bundles that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package dmfe_pkg;

  // Frame markers: two of OPEN_MARK open a frame, two of CLOSE_MARK close it
  localparam logic [7:0] OPEN_MARK  = 8'h3C;
  localparam logic [7:0] CLOSE_MARK = 8'h3E;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // take the input byte this cycle
    logic load_empty;  // load an empty-frame result into the output register
    logic rd_en;       // read the payload buffer at the emit index
    logic load_byte;   // load the read byte into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic close_hit;   // input byte completes a close pair inside a frame
    logic len_zero;    // frame being closed now holds no payload
    logic is_last;     // byte at the emit index is the final one
    logic slot_free;   // output register can take a result this cycle
  } sts_t;

endpackage

FILE: rtl/core/double_marker_frame_extractor.sv
// ----------------------------------------------------------------------------
// double_marker_frame_extractor: delimited frame deframer
// Cuts frames opened by "<<" and closed by ">>" out of a byte stream.
//
// Slave channel: one received byte per request on s_axis_tdata_i.
// Master channel: payload bytes of each completed frame, tlast on the final
// byte; an empty frame gives one request with tuser set and tdata zero.
// Throughput: one input byte per cycle while no frame is being emitted.
// A close pair stops input for the emission: each payload byte takes one payload
// buffer read and then one output register load, and an empty frame one output
// register load; the receiver holding tready low stalls the emission further.
// After the closing byte the first result passes the READ state, the buffer read
// register and the PUSH state into the output register; an empty frame only EMPTY.
// The output register lets the last result wait for the receiver while the
// next input byte is already taken.
// Reset clears marker history, capture state and the output valid flag; the
// payload buffer holds no reset value and needs no clearing pass.
// A frame longer than BUFFER_CAPACITY - 2 bytes is dropped.
// ----------------------------------------------------------------------------
module double_marker_frame_extractor #(
  parameter int unsigned BUFFER_CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,
  output logic       m_axis_tuser_o    // [0] empty_frame
);
  import dmfe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller
  dmfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  dmfe_dpath #(
    .BUFFER_CAPACITY (BUFFER_CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_byte_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_empty_o (m_axis_tuser_o)
  );

endmodule

FILE: rtl/core/dmfe_ctrl.sv
// ----------------------------------------------------------------------------
// dmfe_ctrl: frame extractor controller
// Accepts bytes while idle; after a close pair loads an empty-frame result or
// walks the payload buffer, one read and one output load per emitted byte.
// ----------------------------------------------------------------------------
module dmfe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dmfe_pkg::sts_t sts_i,
  output dmfe_pkg::cmd_t cmd_o
);
  import dmfe_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_READ,
    ST_PUSH
  } state_e;

  state_e state_q, state_d;

  // Command decode
  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    cmd_o            = '0;
    cmd_o.accept     = in_valid_i && (state_q == ST_IDLE);
    cmd_o.load_empty = (state_q == ST_EMPTY) && sts_i.slot_free;
    cmd_o.rd_en      = (state_q == ST_READ);
    cmd_o.load_byte  = (state_q == ST_PUSH) && sts_i.slot_free;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept && sts_i.close_hit) begin
          state_d = sts_i.len_zero ? ST_EMPTY : ST_READ;
        end
      end
      ST_EMPTY: begin
        if (sts_i.slot_free) state_d = ST_IDLE;
      end
      ST_READ: begin
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (sts_i.slot_free) state_d = sts_i.is_last ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/dmfe_dpath.sv
// ----------------------------------------------------------------------------
// dmfe_dpath: frame extractor datapath
// Marker detection, payload buffer, fill/emit counters and the output
// register of the result stream.
// ----------------------------------------------------------------------------
module dmfe_dpath #(
  parameter int unsigned BUFFER_CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dmfe_pkg::cmd_t cmd_i,
  output dmfe_pkg::sts_t sts_o,
  input  logic [7:0]     in_byte_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o,
  output logic           out_empty_o
);
  import dmfe_pkg::*;

  localparam int unsigned IdxW = $clog2(BUFFER_CAPACITY);

  logic [7:0]      prev_q, prev_d;
  logic            cap_q, cap_d;
  logic [IdxW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] len_q, len_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      mem_q [BUFFER_CAPACITY];
  logic [7:0]      rd_q;
  logic            wr_en;
  logic            open_hit;
  logic            close_hit;
  logic            full;
  logic            ovalid_q;
  logic [7:0]      obyte_q;
  logic            olast_q;
  logic            oempty_q;

  // Marker detection on the incoming byte
  assign open_hit  = (prev_q == OPEN_MARK) && (in_byte_i == OPEN_MARK);
  assign close_hit = !open_hit && cap_q && (prev_q == CLOSE_MARK)
                     && (in_byte_i == CLOSE_MARK);
  assign full      = (fill_q == IdxW'(BUFFER_CAPACITY - 1));
  assign wr_en     = cmd_i.accept && cap_q && !open_hit && !close_hit && !full;

  // Status toward the controller
  assign sts_o.close_hit = close_hit;
  assign sts_o.len_zero  = (fill_q <= IdxW'(1));
  assign sts_o.is_last   = ((idx_q + IdxW'(1)) == len_q);
  assign sts_o.slot_free = !ovalid_q || out_ready_i;

  // Frame state update
  always_comb begin
    prev_d = prev_q;
    cap_d  = cap_q;
    fill_d = fill_q;
    len_d  = len_q;
    idx_d  = idx_q;
    if (cmd_i.accept) begin
      if (open_hit) begin
        cap_d  = 1'b1;
        fill_d = '0;
        prev_d = '0;
      end else if (close_hit) begin
        // drop the stored first close marker
        cap_d  = 1'b0;
        fill_d = '0;
        prev_d = '0;
        len_d  = (fill_q == '0) ? '0 : fill_q - IdxW'(1);
        idx_d  = '0;
      end else begin
        if (cap_q) begin
          if (full) begin
            cap_d  = 1'b0;
            fill_d = '0;
          end else begin
            fill_d = fill_q + IdxW'(1);
          end
        end
        prev_d = in_byte_i;
      end
    end
    if (cmd_i.load_byte) idx_d = idx_q + IdxW'(1);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      cap_q  <= 1'b0;
      fill_q <= '0;
      len_q  <= '0;
      idx_q  <= '0;
    end else begin
      prev_q <= prev_d;
      cap_q  <= cap_d;
      fill_q <= fill_d;
      len_q  <= len_d;
      idx_q  <= idx_d;
    end
  end

  // Payload buffer, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[fill_q] <= in_byte_i;
    if (cmd_i.rd_en) rd_q <= mem_q[idx_q];
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.load_empty || cmd_i.load_byte) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_empty) begin
      obyte_q  <= '0;
      olast_q  <= 1'b1;
      oempty_q <= 1'b1;
    end else if (cmd_i.load_byte) begin
      obyte_q  <= rd_q;
      olast_q  <= sts_o.is_last;
      oempty_q <= 1'b0;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;
  assign out_empty_o = oempty_q;

endmodule

FILE: bench/double_marker_frame_extractor_test.sv
// ----------------------------------------------------------------------------
// double_marker_frame_extractor_test: self-checking bench for the deframer
// Streams bytes into the block and predicts every payload request it must
// emit, comparing each output request field by field in arrival order.
// Covers basic, empty, restarted and broken frames, the longest frame and
// buffer overflow, random traffic, and a long output stall.
// ----------------------------------------------------------------------------
module double_marker_frame_extractor_test;
  import dmfe_pkg::*;

  localparam int unsigned BUF_CAP = 64;

  // One expected output request
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } frame_beat_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = 8'h00;  // [7:0] in_byte
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;           // [7:0] out_byte
  logic       m_axis_tlast_o;
  logic       m_axis_tuser_o;           // [0] empty_frame

  double_marker_frame_extractor #(
    .BUFFER_CAPACITY(BUF_CAP)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Deframer shadow state
  logic [7:0]  last_rx_byte;
  logic        in_frame;
  int unsigned held_bytes;
  logic [7:0]  frame_buf [BUF_CAP];
  frame_beat_t pending_beats [$];

  // Bookkeeping
  int errors       = 0;
  int bytes_sent   = 0;
  int beats_seen   = 0;
  int frames_done  = 0;
  int empty_frames = 0;
  int overflows    = 0;
  int restarts     = 0;
  bit gaps_on      = 1'b0;
  int ready_hold_cycles = 0;

  // Shadow deframer: update state for one received byte, queue its payload
  function automatic void deframe_byte(input logic [7:0] b);
    int unsigned len;
    frame_beat_t beat;
    if (last_rx_byte == OPEN_MARK && b == OPEN_MARK) begin
      if (in_frame) restarts++;
      in_frame     = 1'b1;
      held_bytes   = 0;
      last_rx_byte = 8'h00;
      return;
    end
    if (in_frame) begin
      if (last_rx_byte == CLOSE_MARK && b == CLOSE_MARK) begin
        // drop the stored first close marker
        len = (held_bytes > 0) ? held_bytes - 1 : 0;
        if (len == 0) begin
          beat.data  = 8'h00;
          beat.last  = 1'b1;
          beat.empty = 1'b1;
          pending_beats.push_back(beat);
          empty_frames++;
        end else begin
          for (int unsigned k = 0; k < len; k++) begin
            beat.data  = frame_buf[k];
            beat.last  = (k + 1 == len);
            beat.empty = 1'b0;
            pending_beats.push_back(beat);
          end
        end
        frames_done++;
        in_frame     = 1'b0;
        held_bytes   = 0;
        last_rx_byte = 8'h00;
        return;
      end
      if (held_bytes + 1 >= BUF_CAP) begin
        // buffer full: abort capture, byte dropped
        in_frame   = 1'b0;
        held_bytes = 0;
        overflows++;
      end else begin
        frame_buf[held_bytes] = b;
        held_bytes++;
      end
    end
    last_rx_byte = b;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random byte that is not a frame marker
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == OPEN_MARK || b == CLOSE_MARK);
    return b;
  endfunction

  // Offer one byte and wait for the request to be taken
  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    gap = gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // Open pair, n payload bytes (some percent of them unrestricted), optional close
  task automatic send_frame(input int n, input int wild_pct, input bit closed);
    send_rx_byte(OPEN_MARK);
    send_rx_byte(OPEN_MARK);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < wild_pct) send_rx_byte(8'($urandom));
      else send_rx_byte(plain_byte());
    end
    if (closed) begin
      send_rx_byte(CLOSE_MARK);
      send_rx_byte(CLOSE_MARK);
    end
  endtask

  // Stop sending and let all expected output drain
  task automatic wait_drain();
    int n;
    n = 0;
    s_axis_tvalid_i <= 1'b0;
    while (pending_beats.size() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Directed frames, no idling on either side
  task automatic test_basic_frames();
    gaps_on = 1'b0;
    // extreme payload values, zero byte passes through
    send_rx_byte(OPEN_MARK);
    send_rx_byte(OPEN_MARK);
    send_rx_byte(8'h00);
    send_rx_byte(8'hFF);
    send_rx_byte(CLOSE_MARK);
    send_rx_byte(CLOSE_MARK);
    // empty frame
    send_frame(0, 0, 1'b1);
    // close pair with no frame open
    send_rx_byte(CLOSE_MARK);
    send_rx_byte(CLOSE_MARK);
    // open pair in mid-frame restarts capture
    send_rx_byte(OPEN_MARK);
    send_rx_byte(OPEN_MARK);
    send_rx_byte(8'h78);
    send_frame(1, 0, 1'b1);
    // lone markers as payload
    send_rx_byte(OPEN_MARK);
    send_rx_byte(OPEN_MARK);
    send_rx_byte(OPEN_MARK);
    send_rx_byte(CLOSE_MARK);
    send_rx_byte(8'h61);
    send_rx_byte(CLOSE_MARK);
    send_rx_byte(CLOSE_MARK);
    wait_drain();
  endtask

  // Longest frame that fits, one that overflows, then recovery
  task automatic test_length_limits();
    gaps_on = 1'b1;
    send_frame(BUF_CAP - 2, 0, 1'b1);
    wait_drain();
    send_frame(BUF_CAP - 1, 0, 1'b1);
    send_frame(BUF_CAP + 3, 0, 1'b1);
    send_frame(2, 0, 1'b1);
    wait_drain();
  endtask

  // Random traffic: mostly well-formed frames, some noise and broken frames
  task automatic test_random_stream();
    int stop_at;
    int r;
    int n;
    gaps_on = 1'b1;
    stop_at = bytes_sent + 130;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 20) begin
        n = $urandom_range(1, 4);
        repeat (n) send_rx_byte(8'($urandom));
      end
      r = $urandom_range(0, 99);
      if (r < 80) n = $urandom_range(0, 8);
      else if (r < 95) n = $urandom_range(9, 40);
      else n = $urandom_range(BUF_CAP - 6, BUF_CAP + 2);
      send_frame(n, 10, $urandom_range(0, 99) < 88);
      if ($urandom_range(0, 99) < 5) send_rx_byte(CLOSE_MARK);
    end
    wait_drain();
  endtask

  // Receiver stalls for a long stretch while input keeps coming
  task automatic test_output_stall();
    gaps_on = 1'b0;
    ready_hold_cycles = 300;
    repeat (4) send_frame($urandom_range(6, 12), 0, 1'b1);
    gaps_on = 1'b1;
    wait_drain();
  endtask

  // Receiver ready: long hold when asked, else random idling
  initial begin : drive_sink
    int gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk_i);
      if (ready_hold_cycles > 0) begin
        ready_hold_cycles--;
        m_axis_tready_i <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_axis_tready_i <= 1'b0;
      end else if (gaps_on) begin
        gap_left = idle_len();
        m_axis_tready_i <= (gap_left == 0);
        if (gap_left > 0) gap_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Compare each output request with the oldest expectation
  initial begin : check_beats
    frame_beat_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        beats_seen++;
        if (pending_beats.size() == 0) begin
          $display("%0t: expected no request, actual data=%h last=%b empty=%b",
                   $time, m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
          errors++;
        end else begin
          want = pending_beats.pop_front();
          if (m_axis_tdata_o !== want.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.data,
                     m_axis_tdata_o);
            errors++;
          end
          if (m_axis_tlast_o !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last,
                     m_axis_tlast_o);
            errors++;
          end
          if (m_axis_tuser_o !== want.empty) begin
            $display("%0t: empty_frame expected %b actual %b", $time, want.empty,
                     m_axis_tuser_o);
            errors++;
          end
        end
      end
    end
  end

  // Run limit
  initial begin : watchdog
    #5000000;
    $display("%0t: timeout", $time);
    $display("FAIL double_marker_frame_extractor");
    $finish;
  end

  initial begin : run_tests
    last_rx_byte = 8'h00;
    in_frame     = 1'b0;
    held_bytes   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_frames();
    test_length_limits();
    test_random_stream();
    test_output_stall();

    if (pending_beats.size() != 0) begin
      $display("%0t: %0d expected requests never arrived", $time, pending_beats.size());
      errors++;
    end
    $display("Sent %0d bytes, checked %0d output requests from %0d frames.",
             bytes_sent, beats_seen, frames_done);
    $display("Saw %0d empty frames, %0d overflow aborts, %0d mid-frame restarts.",
             empty_frames, overflows, restarts);
    if (errors == 0) begin
      $display("PASS double_marker_frame_extractor");
    end else begin
      $display("FAIL double_marker_frame_extractor");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/dmfe_pkg.sv
rtl/core/dmfe_ctrl.sv
rtl/core/dmfe_dpath.sv
rtl/core/double_marker_frame_extractor.sv
bench/double_marker_frame_extractor_test.sv
